### rtl/dcpd_pkg.sv
// Shared types and constants for the DAC channel pattern driver.
// No dependencies; used by every module of the block.
package dcpd_pkg;

	localparam logic [7:0]  BASE_ADDR = 8'd48;
	localparam logic [15:0] MID_CODE  = 16'h8000;
	localparam logic [15:0] FULL_CODE = 16'hFFFF;
	localparam logic [15:0] ZERO_CODE = 16'h0000;
	localparam logic [15:0] NOISE_HI  = 16'hAAAA;
	localparam logic [15:0] NOISE_LO  = 16'h5555;

	localparam logic [7:0] NOISE_ZEROS = 8'd0;
	localparam logic [7:0] NOISE_ONES  = 8'd1;
	localparam logic [7:0] NOISE_RAIL  = 8'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QW          = $clog2(QUEUE_DEPTH);

	// Command codes on the input port
	typedef enum logic [3:0] {
		FN_TICK       = 4'd0,
		FN_SET_CH     = 4'd1,
		FN_SET_ALL    = 4'd2,
		FN_NUDGE_UP   = 4'd3,
		FN_NUDGE_DN   = 4'd4,
		FN_SQ_SINGLE  = 4'd5,
		FN_SQ_SYNC    = 4'd6,
		FN_SQ_ALT     = 4'd7,
		FN_BUS_NOISE  = 4'd8
	} func_t;

	// Classified operations handed from front to back
	typedef enum logic [3:0] {
		OP_TICK,
		OP_SET_CH,
		OP_SET_ALL,
		OP_NUDGE_UP,
		OP_NUDGE_DN,
		OP_START_SINGLE,
		OP_START_SYNC,
		OP_START_ALT,
		OP_START_NOISE,
		OP_BUS_DRIVE,
		OP_STOP
	} op_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_SINGLE,
		MODE_SYNC,
		MODE_ALT,
		MODE_NOISE
	} mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} back_state_t;

	typedef struct packed {
		op_t         op;
		logic [2:0]  ch;
		logic [15:0] hi;
		logic [15:0] lo;
	} cmd_t;

endpackage

### rtl/dac_channel_pattern_driver.sv
// Top level of the DAC channel pattern driver: front end, command queue and
// write sequencer. Depends on dcpd_pkg, dcpd_front, dcpd_cmd_queue, dcpd_back.
//
// Usage:
//   Command channel (cmd_valid/cmd_ready): one beat carries func, channel,
//   code_high, code_low and noise_option. The front end classifies it and
//   queues it (two entries), so commands are taken while writes drain.
//   Write channel (wr_valid/wr_ready): each beat is one bus write with
//   bus_address (48 + channel, or 0 for an unstrobed drive), bus_data,
//   strobe_res and last_write, set on the final beat of a command.
//   Flow: a command is written into the queue, then popped by the sequencer,
//   which registers its write into the output register. A single write or
//   state-only command is handled in the idle state; set-all and sync or
//   alternating ticks load the sweep, then one write per cycle unless stalled.
//   Stall: while wr_ready is low the sequencer holds, the queue fills and
//   cmd_ready drops once both entries are occupied. No beat is lost.
//   Reset (arst_n low): all channel codes go to 0x8000, the current channel
//   to 0, the mode to idle, toggle and levels to 0; the queue empties.
module dac_channel_pattern_driver import dcpd_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [3:0]  func,
	input  logic [2:0]  channel,
	input  logic [15:0] code_high,
	input  logic [15:0] code_low,
	input  logic [7:0]  noise_option,
	output logic        wr_valid,
	input  logic        wr_ready,
	output logic [7:0]  bus_address,
	output logic [15:0] bus_data,
	output logic        strobe_res,
	output logic        last_write
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_empty;
	logic pop;
	cmd_t pop_cmd;

	dcpd_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.func        (func),
		.channel     (channel),
		.code_high   (code_high),
		.code_low    (code_low),
		.noise_option(noise_option),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	dcpd_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.pop_cmd (pop_cmd),
		.empty   (q_empty)
	);

	dcpd_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_cmd      (pop_cmd),
		.pop        (pop),
		.wr_valid   (wr_valid),
		.wr_ready   (wr_ready),
		.bus_address(bus_address),
		.bus_data   (bus_data),
		.strobe_res (strobe_res),
		.last_write (last_write)
	);

endmodule

### rtl/dcpd_front.sv
// Front end: takes command beats and classifies them into queue entries.
// Depends on dcpd_pkg.
module dcpd_front import dcpd_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [3:0]  func,
	input  logic [2:0]  channel,
	input  logic [15:0] code_high,
	input  logic [15:0] code_low,
	input  logic [7:0]  noise_option,
	input  logic        q_full,
	output logic        push,
	output cmd_t        push_cmd
);

	logic ch_ok;

	assign ch_ok     = {1'b0, channel} < 4'(CHANNELS);
	assign cmd_ready = !q_full;
	assign push      = cmd_valid && !q_full;

	always_comb begin
		push_cmd.op = OP_STOP;
		push_cmd.ch = channel;
		push_cmd.hi = code_high;
		push_cmd.lo = code_low;
		case (func)
			FN_TICK:      push_cmd.op = OP_TICK;
			FN_SET_CH:    push_cmd.op = ch_ok ? OP_SET_CH : OP_STOP;
			FN_SET_ALL:   push_cmd.op = OP_SET_ALL;
			FN_NUDGE_UP:  push_cmd.op = OP_NUDGE_UP;
			FN_NUDGE_DN:  push_cmd.op = OP_NUDGE_DN;
			FN_SQ_SINGLE: push_cmd.op = ch_ok ? OP_START_SINGLE : OP_STOP;
			FN_SQ_SYNC:   push_cmd.op = OP_START_SYNC;
			FN_SQ_ALT:    push_cmd.op = OP_START_ALT;
			FN_BUS_NOISE: begin
				if (noise_option == NOISE_ZEROS) begin
					push_cmd.op = OP_BUS_DRIVE;
					push_cmd.hi = ZERO_CODE;
				end else if (noise_option == NOISE_ONES) begin
					push_cmd.op = OP_BUS_DRIVE;
					push_cmd.hi = FULL_CODE;
				end else if (noise_option == NOISE_RAIL) begin
					push_cmd.op = OP_START_NOISE;
					push_cmd.hi = FULL_CODE;
					push_cmd.lo = ZERO_CODE;
				end else begin
					push_cmd.op = OP_START_NOISE;
					push_cmd.hi = NOISE_HI;
					push_cmd.lo = NOISE_LO;
				end
			end
			default:      push_cmd.op = OP_STOP;
		endcase
	end

endmodule

### rtl/dcpd_cmd_queue.sv
// Short command queue between the front end and the write sequencer.
// Depends on dcpd_pkg.
module dcpd_cmd_queue import dcpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [QW:0]   count_q;

	assign full    = count_q == (QW+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

### rtl/dcpd_back.sv
// Back end: holds channel codes and run mode, executes queued commands and
// sequences bus writes into the output register. Depends on dcpd_pkg.
module dcpd_back import dcpd_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        pop,
	output logic        wr_valid,
	input  logic        wr_ready,
	output logic [7:0]  bus_address,
	output logic [15:0] bus_data,
	output logic        strobe_res,
	output logic        last_write
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	back_state_t   state_q, state_d;
	mode_t         mode_q, mode_d;
	logic          toggle_q, toggle_d;
	logic [15:0]   lvl_hi_q, lvl_hi_d;
	logic [15:0]   lvl_lo_q, lvl_lo_d;
	logic [CW-1:0] cur_q, cur_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [15:0]   even_q, even_d;
	logic [15:0]   odd_q, odd_d;
	logic [15:0]   codes_q [CHANNELS];

	logic          can_emit;
	logic          emit;
	logic [7:0]    emit_addr;
	logic [15:0]   emit_data;
	logic          emit_strobe;
	logic          emit_last;
	logic          code_we;
	logic [CW-1:0] code_idx;
	logic [15:0]   code_wdata;
	logic [15:0]   cur_code;
	logic          tog_n;
	logic [15:0]   tog_val;
	logic [CW-1:0] q_ch;
	logic          sweep_last;

	assign can_emit   = !wr_valid || wr_ready;
	assign cur_code   = codes_q[cur_q];
	assign tog_n      = !toggle_q;
	assign tog_val    = tog_n ? lvl_hi_q : lvl_lo_q;
	assign q_ch       = q_cmd.ch[CW-1:0];
	assign sweep_last = idx_q == CW'(CHANNELS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		toggle_d    = toggle_q;
		lvl_hi_d    = lvl_hi_q;
		lvl_lo_d    = lvl_lo_q;
		cur_d       = cur_q;
		idx_d       = idx_q;
		even_d      = even_q;
		odd_d       = odd_q;
		pop         = 1'b0;
		emit        = 1'b0;
		emit_addr   = BASE_ADDR + 8'(cur_q);
		emit_data   = tog_val;
		emit_strobe = 1'b1;
		emit_last   = 1'b1;
		code_we     = 1'b0;
		code_idx    = cur_q;
		code_wdata  = tog_val;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty && can_emit) begin
					pop = 1'b1;
					if (q_cmd.op != OP_TICK) begin
						mode_d = MODE_IDLE;
					end
					case (q_cmd.op)
						OP_TICK: begin
							if (mode_q != MODE_IDLE) begin
								toggle_d = tog_n;
							end
							case (mode_q)
								MODE_SINGLE: begin
									code_we = 1'b1;
									emit    = 1'b1;
								end
								MODE_NOISE: begin
									emit        = 1'b1;
									emit_addr   = '0;
									emit_strobe = 1'b0;
								end
								MODE_SYNC: begin
									state_d = ST_SWEEP;
									idx_d   = '0;
									even_d  = tog_val;
									odd_d   = tog_val;
								end
								MODE_ALT: begin
									state_d = ST_SWEEP;
									idx_d   = '0;
									even_d  = tog_n ? lvl_hi_q : lvl_lo_q;
									odd_d   = tog_n ? lvl_lo_q : lvl_hi_q;
								end
								default: ;
							endcase
						end
						OP_SET_CH: begin
							cur_d      = q_ch;
							code_we    = 1'b1;
							code_idx   = q_ch;
							code_wdata = q_cmd.hi;
							emit       = 1'b1;
							emit_addr  = BASE_ADDR + 8'(q_ch);
							emit_data  = q_cmd.hi;
						end
						OP_SET_ALL: begin
							state_d = ST_SWEEP;
							idx_d   = '0;
							even_d  = q_cmd.hi;
							odd_d   = q_cmd.hi;
						end
						OP_NUDGE_UP: begin
							if (cur_code != FULL_CODE) begin
								code_we    = 1'b1;
								code_wdata = cur_code + 16'd1;
								emit       = 1'b1;
								emit_data  = cur_code + 16'd1;
							end
						end
						OP_NUDGE_DN: begin
							if (cur_code != ZERO_CODE) begin
								code_we    = 1'b1;
								code_wdata = cur_code - 16'd1;
								emit       = 1'b1;
								emit_data  = cur_code - 16'd1;
							end
						end
						OP_START_SINGLE: begin
							cur_d    = q_ch;
							lvl_hi_d = q_cmd.hi;
							lvl_lo_d = q_cmd.lo;
							mode_d   = MODE_SINGLE;
						end
						OP_START_SYNC: begin
							lvl_hi_d = q_cmd.hi;
							lvl_lo_d = q_cmd.lo;
							mode_d   = MODE_SYNC;
						end
						OP_START_ALT: begin
							lvl_hi_d = q_cmd.hi;
							lvl_lo_d = q_cmd.lo;
							mode_d   = MODE_ALT;
						end
						OP_START_NOISE: begin
							lvl_hi_d = q_cmd.hi;
							lvl_lo_d = q_cmd.lo;
							mode_d   = MODE_NOISE;
						end
						OP_BUS_DRIVE: begin
							emit        = 1'b1;
							emit_addr   = '0;
							emit_data   = q_cmd.hi;
							emit_strobe = 1'b0;
						end
						default: ;
					endcase
				end
			end
			ST_SWEEP: begin
				// one strobed write per channel, ascending
				if (can_emit) begin
					code_we    = 1'b1;
					code_idx   = idx_q;
					code_wdata = idx_q[0] ? odd_q : even_q;
					emit       = 1'b1;
					emit_addr  = BASE_ADDR + 8'(idx_q);
					emit_data  = idx_q[0] ? odd_q : even_q;
					emit_last  = sweep_last;
					idx_d      = idx_q + 1'b1;
					if (sweep_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			toggle_q <= 1'b0;
			lvl_hi_q <= '0;
			lvl_lo_q <= '0;
			cur_q    <= '0;
			idx_q    <= '0;
			wr_valid <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				codes_q[i] <= MID_CODE;
			end
		end else begin
			mode_q   <= mode_d;
			toggle_q <= toggle_d;
			lvl_hi_q <= lvl_hi_d;
			lvl_lo_q <= lvl_lo_d;
			cur_q    <= cur_d;
			idx_q    <= idx_d;
			if (code_we) begin
				codes_q[code_idx] <= code_wdata;
			end
			if (emit) begin
				wr_valid <= 1'b1;
			end else if (wr_ready) begin
				wr_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		even_q <= even_d;
		odd_q  <= odd_d;
		if (emit) begin
			bus_address <= emit_addr;
			bus_data    <= emit_data;
			strobe_res  <= emit_strobe;
			last_write  <= emit_last;
		end
	end

`ifndef SYNTHESIS
	a_unstrobed_addr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && !strobe_res |-> bus_address == 8'd0 && last_write)
		else $error("unstrobed beat with address or not last");
	a_sweep_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> !pop) else $error("queue popped during sweep");
	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP && can_emit && sweep_last |=> state_q == ST_IDLE
		&& wr_valid && last_write) else $error("sweep did not close with last beat");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench for dac_channel_pattern_driver: directed and random commands,
// with bus writes checked against an in-bench model of the channel codes and modes.
// Depends on dcpd_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
	import dcpd_pkg::*;

	localparam int NUM_CH        = 8;
	localparam int SETTLE_CYCLES = 16;
	localparam int RUN_LIMIT_NS  = 5_000_000;
	localparam logic [3:0] FN_CODE_MAX = 4'hF;

	typedef struct packed {
		logic [7:0]  addr;
		logic [15:0] data;
		logic        strobe;
		logic        last_beat;
	} bus_write_t;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	logic [3:0]  func;
	logic [2:0]  channel;
	logic [15:0] code_high;
	logic [15:0] code_low;
	logic [7:0]  noise_option;
	logic        wr_valid;
	logic        wr_ready = 1'b0;
	logic [7:0]  bus_address;
	logic [15:0] bus_data;
	logic        strobe_res;
	logic        last_write;

	logic        gaps_on = 1'b1;
	int          err_count = 0;

	// model state of the driver
	logic [15:0] ch_code [NUM_CH];
	logic [2:0]  cur_ch;
	mode_t       run_state;
	logic        phase;
	logic [15:0] lvl_hi;
	logic [15:0] lvl_lo;

	bus_write_t  bus_writes_due [$];

	dac_channel_pattern_driver #(
		.CHANNELS(NUM_CH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.func(func),
		.channel(channel),
		.code_high(code_high),
		.code_low(code_low),
		.noise_option(noise_option),
		.wr_valid(wr_valid),
		.wr_ready(wr_ready),
		.bus_address(bus_address),
		.bus_data(bus_data),
		.strobe_res(strobe_res),
		.last_write(last_write)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("dac_channel_pattern_driver regression: fail");
		$finish;
	end

	function automatic void reset_model();
		for (int i = 0; i < NUM_CH; i++)
			ch_code[i] = MID_CODE;
		cur_ch    = '0;
		run_state = MODE_IDLE;
		phase     = 1'b0;
		lvl_hi    = '0;
		lvl_lo    = '0;
	endfunction

	function automatic void push_write(input logic [7:0] a, input logic [15:0] d,
			input logic s);
		bus_write_t w;
		w = '{addr: a, data: d, strobe: s, last_beat: 1'b0};
		bus_writes_due.push_back(w);
	endfunction

	function automatic void write_channel(input int idx);
		push_write(BASE_ADDR + 8'(idx), ch_code[idx], 1'b1);
	endfunction

	function automatic void tick_writes();
		logic up;
		if (run_state == MODE_IDLE)
			return;
		phase = ~phase;
		case (run_state)
			MODE_SINGLE: begin
				ch_code[cur_ch] = phase ? lvl_hi : lvl_lo;
				write_channel(cur_ch);
			end
			MODE_SYNC: begin
				for (int i = 0; i < NUM_CH; i++) begin
					ch_code[i] = phase ? lvl_hi : lvl_lo;
					write_channel(i);
				end
			end
			MODE_ALT: begin
				// even channels take the high level while the toggle is set
				for (int i = 0; i < NUM_CH; i++) begin
					up = ((i % 2) == 0) == phase;
					ch_code[i] = up ? lvl_hi : lvl_lo;
					write_channel(i);
				end
			end
			default: push_write(8'd0, phase ? lvl_hi : lvl_lo, 1'b0);
		endcase
	endfunction

	function automatic void predict_command(input logic [3:0] fn, input logic [2:0] ch,
			input logic [15:0] hi, input logic [15:0] lo, input logic [7:0] opt);
		int n_queued;
		n_queued = bus_writes_due.size();
		if (fn == FN_TICK) begin
			tick_writes();
		end else begin
			run_state = MODE_IDLE;
			case (fn)
				FN_SET_CH: begin
					cur_ch = ch;
					ch_code[ch] = hi;
					write_channel(ch);
				end
				FN_SET_ALL: begin
					for (int i = 0; i < NUM_CH; i++) begin
						ch_code[i] = hi;
						write_channel(i);
					end
				end
				FN_NUDGE_UP: begin
					if (ch_code[cur_ch] != FULL_CODE) begin
						ch_code[cur_ch] = ch_code[cur_ch] + 16'd1;
						write_channel(cur_ch);
					end
				end
				FN_NUDGE_DN: begin
					if (ch_code[cur_ch] != ZERO_CODE) begin
						ch_code[cur_ch] = ch_code[cur_ch] - 16'd1;
						write_channel(cur_ch);
					end
				end
				FN_SQ_SINGLE: begin
					cur_ch    = ch;
					lvl_hi    = hi;
					lvl_lo    = lo;
					run_state = MODE_SINGLE;
				end
				FN_SQ_SYNC: begin
					lvl_hi    = hi;
					lvl_lo    = lo;
					run_state = MODE_SYNC;
				end
				FN_SQ_ALT: begin
					lvl_hi    = hi;
					lvl_lo    = lo;
					run_state = MODE_ALT;
				end
				FN_BUS_NOISE: begin
					if (opt == NOISE_ZEROS) begin
						push_write(8'd0, ZERO_CODE, 1'b0);
					end else if (opt == NOISE_ONES) begin
						push_write(8'd0, FULL_CODE, 1'b0);
					end else begin
						if (opt == NOISE_RAIL) begin
							lvl_hi = FULL_CODE;
							lvl_lo = ZERO_CODE;
						end else begin
							lvl_hi = NOISE_HI;
							lvl_lo = NOISE_LO;
						end
						run_state = MODE_NOISE;
					end
				end
				default: ;
			endcase
		end
		if (bus_writes_due.size() > n_queued)
			bus_writes_due[bus_writes_due.size() - 1].last_beat = 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			err_count++;
		end
	endfunction

	// prediction on each command beat, checking on each write beat
	always @(posedge clk) begin
		bus_write_t want;
		if (!arst_n) begin
			reset_model();
			bus_writes_due.delete();
		end else begin
			if (cmd_valid && cmd_ready)
				predict_command(func, channel, code_high, code_low, noise_option);
			if (wr_valid && wr_ready) begin
				if (bus_writes_due.size() == 0) begin
					$error("write beat with nothing expected: addr 0x%0h data 0x%0h",
						bus_address, bus_data);
					err_count++;
				end else begin
					want = bus_writes_due.pop_front();
					check_field("bus_address", 16'(want.addr), 16'(bus_address));
					check_field("bus_data", want.data, bus_data);
					check_field("strobe_res", 16'(want.strobe), 16'(strobe_res));
					check_field("last_write", 16'(want.last_beat), 16'(last_write));
				end
			end
		end
	end

	// write side back-pressure in random bursts
	always @(posedge clk) begin
		static int  hold_left = 0;
		static bit  stalling  = 1'b0;
		if (hold_left == 0) begin
			stalling  = gaps_on && ($urandom_range(0, 2) == 0);
			hold_left = stalling ? $urandom_range(1, 18) : $urandom_range(1, 24);
		end
		hold_left--;
		wr_ready <= !(stalling && gaps_on);
	end

	// Leaves cmd_valid high after the beat so back-to-back beats need no re-raise.
	task automatic send_cmd(input logic [3:0] fn, input logic [2:0] ch,
			input logic [15:0] hi, input logic [15:0] lo, input logic [7:0] opt);
		int gap;
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 18);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid    <= 1'b1;
		func         <= fn;
		channel      <= ch;
		code_high    <= hi;
		code_low     <= lo;
		noise_option <= opt;
		do
			@(posedge clk);
		while (!cmd_ready);
	endtask

	task automatic send_rand(input logic [3:0] fn);
		send_cmd(fn, 3'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	task automatic wait_writes_drained();
		cmd_valid <= 1'b0;
		while (bus_writes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_set_and_nudge();
		send_cmd(FN_SET_CH, 3'd0, FULL_CODE, 16'h0000, 8'h00);
		send_cmd(FN_NUDGE_UP, 3'd7, 16'h0000, 16'hFFFF, 8'hFF);   // saturated
		send_cmd(FN_NUDGE_DN, 3'd3, 16'h1234, 16'h0000, 8'h00);
		send_cmd(FN_SET_CH, 3'd7, ZERO_CODE, 16'hFFFF, 8'hFF);
		send_cmd(FN_NUDGE_DN, 3'd0, 16'hFFFF, 16'hFFFF, 8'h00);   // saturated
		send_cmd(FN_NUDGE_UP, 3'd0, 16'h0000, 16'h0000, 8'h00);
		send_cmd(FN_SET_ALL, 3'd5, 16'h1234, 16'hFFFF, 8'hFF);
	endtask

	task automatic test_square_modes();
		send_cmd(FN_SQ_SINGLE, 3'd5, FULL_CODE, ZERO_CODE, 8'h00);
		send_cmd(FN_TICK, 3'd0, 16'h0000, 16'h0000, 8'h00);
		send_cmd(FN_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_cmd(FN_SQ_SYNC, 3'd0, 16'h00FF, 16'hFF00, 8'h00);
		send_cmd(FN_TICK, 3'd0, 16'h0000, 16'h0000, 8'h00);
		send_cmd(FN_SQ_ALT, 3'd2, 16'hC3C3, 16'h3C3C, 8'h03);
		send_cmd(FN_TICK, 3'd0, 16'h0000, 16'h0000, 8'h00);
		send_cmd(FN_TICK, 3'd0, 16'h0000, 16'h0000, 8'h00);
		// any non-tick command stops the mode, so the tick after it is silent
		send_cmd(FN_SET_CH, 3'd1, 16'h0001, 16'h0000, 8'h00);
		send_cmd(FN_TICK, 3'd0, 16'h0000, 16'h0000, 8'h00);
	endtask

	task automatic test_bus_noise();
		send_cmd(FN_BUS_NOISE, 3'd0, 16'h0000, 16'h0000, NOISE_ZEROS);
		send_cmd(FN_BUS_NOISE, 3'd7, 16'hFFFF, 16'hFFFF, NOISE_ONES);
		send_cmd(FN_BUS_NOISE, 3'd0, 16'h0000, 16'h0000, NOISE_RAIL);
		send_cmd(FN_TICK, 3'd0, 16'h0000, 16'h0000, 8'h00);
		send_cmd(FN_TICK, 3'd0, 16'h0000, 16'h0000, 8'h00);
		send_cmd(FN_BUS_NOISE, 3'd0, 16'h0000, 16'h0000, 8'hFF);
		send_cmd(FN_TICK, 3'd0, 16'h0000, 16'h0000, 8'h00);
		send_cmd(FN_CODE_MAX, 3'd7, 16'hFFFF, 16'hFFFF, 8'hFF);  // unused code stops the mode
	endtask

	task automatic test_random_traffic(input int n_items);
		int sent;
		int n_ticks;
		int pick;
		bit paused;
		logic [15:0] rail;
		logic [7:0]  opt;
		sent = 0;
		paused = 1'b0;
		while (sent < n_items) begin
			if (sent >= (n_items * 3) / 4)
				gaps_on <= 1'b0;
			if (!paused && sent >= n_items / 2) begin
				wait_writes_drained();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				// a mode start followed by a run of ticks
				case ($urandom_range(0, 3))
					0: send_rand(FN_SQ_SINGLE);
					1: send_rand(FN_SQ_SYNC);
					2: send_rand(FN_SQ_ALT);
					default: begin
						opt = ($urandom_range(0, 1) == 0) ? NOISE_RAIL
							: 8'($urandom_range(2, 255));
						send_cmd(FN_BUS_NOISE, 3'($urandom), 16'($urandom),
							16'($urandom), opt);
					end
				endcase
				n_ticks = $urandom_range(1, 5);
				repeat (n_ticks) send_rand(FN_TICK);
				sent += n_ticks + 1;
			end else if (pick <= 7) begin
				case ($urandom_range(0, 3))
					0: send_rand(FN_SET_CH);
					1: send_rand(FN_SET_ALL);
					2: send_rand(FN_NUDGE_UP);
					default: send_rand(FN_NUDGE_DN);
				endcase
				sent++;
			end else if (pick == 8) begin
				case ($urandom_range(0, 3))
					0: send_cmd(FN_BUS_NOISE, 3'($urandom), 16'($urandom), 16'($urandom),
						NOISE_ZEROS);
					1: send_cmd(FN_BUS_NOISE, 3'($urandom), 16'($urandom), 16'($urandom),
						NOISE_ONES);
					2: send_rand(4'($urandom_range(FN_BUS_NOISE + 1, FN_CODE_MAX)));
					default: send_rand(FN_TICK);
				endcase
				sent++;
			end else begin
				// push a channel to a rail, then nudge into and out of saturation
				rail = ($urandom_range(0, 1) == 0) ? FULL_CODE : ZERO_CODE;
				send_cmd(FN_SET_CH, 3'($urandom), rail, 16'($urandom), 8'($urandom));
				send_rand((rail == FULL_CODE) ? FN_NUDGE_UP : FN_NUDGE_DN);
				send_rand((rail == FULL_CODE) ? FN_NUDGE_DN : FN_NUDGE_UP);
				sent += 3;
			end
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		cmd_valid    <= 1'b0;
		func         <= FN_TICK;
		channel      <= '0;
		code_high    <= '0;
		code_low     <= '0;
		noise_option <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_set_and_nudge();
		test_square_modes();
		test_bus_noise();
		wait_writes_drained();
		test_random_traffic(75);
		wait_writes_drained();

		if (err_count == 0)
			$display("dac_channel_pattern_driver regression: pass");
		else
			$display("dac_channel_pattern_driver regression: fail");
		$finish;
	end

endmodule

### sim.f
rtl/dcpd_pkg.sv
rtl/dcpd_front.sv
rtl/dcpd_cmd_queue.sv
rtl/dcpd_back.sv
rtl/dac_channel_pattern_driver.sv
sim/tb_top.sv
